@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/hvps_pkg.sv @@
// Shared types and constants of the high-voltage precharge sequencer.
// No dependencies; used by the top level and by its checker.
`default_nettype none

package hvps_pkg;

   // Stream payload widths (fields packed from bit 0, padded to bytes).
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;
   localparam int VOLT_W      = 14;
   localparam int CURR_W      = 15;

   // Bit positions in the result beat.
   localparam int RSP_STATE_LSB = 0;
   localparam int RSP_SEV2_BIT  = 3;
   localparam int RSP_SEV1_BIT  = 4;
   localparam int RSP_FAULT_LSB = 5;
   localparam int RSP_WARN_LSB  = 9;

   localparam int unsigned PRECHARGE_TICKS_DEF = 30;
   localparam int unsigned SETTLE_TICKS_DEF    = 10;

   typedef enum logic [2:0] {
      MODE_UNLOCKED  = 3'd0,
      MODE_STANDBY   = 3'd1,
      MODE_PRECHARGE = 3'd2,
      MODE_HV        = 3'd3,
      MODE_RUNNING   = 3'd4,
      MODE_SHUTDOWN  = 3'd5
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VOLT_HIGH_FAULT = 3'd0,
      CSR_VOLT_LOW_FAULT  = 3'd1,
      CSR_VOLT_HIGH_WARN  = 3'd2,
      CSR_VOLT_LOW_WARN   = 3'd3,
      CSR_CURR_HIGH_FAULT = 3'd4,
      CSR_CURR_LOW_FAULT  = 3'd5,
      CSR_CURR_HIGH_WARN  = 3'd6,
      CSR_RELEASE_CURRENT = 3'd7
   } csr_index_type;

   localparam logic [VOLT_W-1:0]        VOLT_HIGH_FAULT_RST = 14'd6500;
   localparam logic [VOLT_W-1:0]        VOLT_LOW_FAULT_RST  = 14'd4000;
   localparam logic [VOLT_W-1:0]        VOLT_HIGH_WARN_RST  = 14'd5000;
   localparam logic [VOLT_W-1:0]        VOLT_LOW_WARN_RST   = 14'd4400;
   localparam logic signed [CURR_W-1:0] CURR_HIGH_FAULT_RST = 15'sd4000;
   localparam logic signed [CURR_W-1:0] CURR_LOW_FAULT_RST  = -15'sd300;
   localparam logic signed [CURR_W-1:0] CURR_HIGH_WARN_RST  = 15'sd3000;
   localparam logic signed [CURR_W-1:0] RELEASE_CURRENT_RST = 15'sd300;

endpackage

`default_nettype wire

@@ sv/hv_precharge_sequencer.sv @@
// Top level of the high-voltage precharge sequencer: alarm latching, mode
// sequencer, dwell counters and result register. Depends on hvps_pkg.
//
//   channel  direction  beat content (lsb first)
//   req_     in         enable, run, precharge/positive/negative closed,
//                       voltage[13:0], current[14:0] signed
//   rsp_     out        state[2:0], sev2, sev1, 4 fault flags, 3 warn flags
//   csr_     in         index[2:0], data[14:0]
//
// For each tick beat the alarm compares and the next mode are worked out in
// the accept cycle, and the result lands in the output register in the next
// cycle. One beat per cycle is taken as long as the output register
// is empty or is drained in the same cycle. Reset (synchronous) restores the
// thresholds, returns the sequencer to unlocked and empties the output.
// csr_ready is always high.
`default_nettype none

module hv_precharge_sequencer #(
   parameter int unsigned PRECHARGE_TICKS = hvps_pkg::PRECHARGE_TICKS_DEF,
   parameter int unsigned SETTLE_TICKS    = hvps_pkg::SETTLE_TICKS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // enable_cmd, run_cmd, precharge_closed, positive_closed, negative_closed,
   // battery_voltage[13:0], discharge_current[14:0], zero pad
   input  wire logic [hvps_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // reported_state[2:0], sev2, sev1, volt_high_fault_flag, volt_low_fault_flag,
   // curr_high_fault_flag, curr_low_fault_flag, volt_high_warn_flag,
   // volt_low_warn_flag, curr_high_warn_flag, zero pad
   output logic [hvps_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [hvps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [hvps_pkg::CSR_DATA_W-1:0]    csr_data
);
   import hvps_pkg::*;

   // Dwell counters saturate at their limit; the advance test only needs
   // to know whether the limit has been reached.
   localparam int PCW = $clog2(PRECHARGE_TICKS + 1);
   localparam int SCW = $clog2(SETTLE_TICKS + 1);
   localparam logic [PCW-1:0] PRE_MAX = PCW'(PRECHARGE_TICKS);
   localparam logic [SCW-1:0] SET_MAX = SCW'(SETTLE_TICKS);

   // Threshold registers.
   logic [VOLT_W-1:0]        volt_high_fault_ff, volt_low_fault_ff;
   logic [VOLT_W-1:0]        volt_high_warn_ff, volt_low_warn_ff;
   logic signed [CURR_W-1:0] curr_high_fault_ff, curr_low_fault_ff;
   logic signed [CURR_W-1:0] curr_high_warn_ff, release_current_ff;

   // Sequencer and alarm state. The severity bits follow from the present
   // causes of each tick, so only the latched cause flags are stored.
   mode_type       mode_ff, mode_in;
   logic [PCW-1:0] pre_cnt_ff, pre_cnt_in, pre_bump;
   logic [SCW-1:0] set_cnt_ff, set_cnt_in, set_bump;
   logic           sev2_in, sev1_in;
   logic [3:0]     fault_ff, fault_in;
   logic [2:0]     warn_ff, warn_in;

   // Output register.
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff;

   logic                     req_fire;
   logic                     en, run, pre, pos, neg;
   logic [VOLT_W-1:0]        volt;
   logic signed [CURR_W-1:0] curr;
   logic                     vhf, vlf, chf, clf, vhw, vlw, chw;
   logic                     stop;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign en   = req_tdata[0];
   assign run  = req_tdata[1];
   assign pre  = req_tdata[2];
   assign pos  = req_tdata[3];
   assign neg  = req_tdata[4];
   assign volt = req_tdata[18:5];
   assign curr = $signed(req_tdata[33:19]);

   // Alarm check.
   assign vhf = volt > volt_high_fault_ff;
   assign vlf = volt < volt_low_fault_ff;
   assign chf = curr > curr_high_fault_ff;
   assign clf = curr < curr_low_fault_ff;
   assign vhw = volt >= volt_high_warn_ff;
   assign vlw = volt <= volt_low_warn_ff;
   assign chw = curr >= curr_high_warn_ff;

   always_comb begin
      // Flags clear only when every cause of their group is gone; otherwise
      // the highest-priority present cause is added to the latched set.
      if (!(vhf || vlf || chf || clf)) begin
         sev2_in  = 1'b0;
         fault_in = '0;
      end else begin
         sev2_in  = 1'b1;
         fault_in = fault_ff;
         if (vhf) begin
            fault_in[0] = 1'b1;
         end else if (vlf) begin
            fault_in[1] = 1'b1;
         end else if (chf) begin
            fault_in[2] = 1'b1;
         end else begin
            fault_in[3] = 1'b1;
         end
      end
      if (!(vhw || vlw || chw)) begin
         sev1_in = 1'b0;
         warn_in = '0;
      end else begin
         sev1_in = 1'b1;
         warn_in = warn_ff;
         if (vhw) begin
            warn_in[0] = 1'b1;
         end else if (vlw) begin
            warn_in[1] = 1'b1;
         end else begin
            warn_in[2] = 1'b1;
         end
      end
   end

   assign stop     = sev2_in || !en || !run;
   assign pre_bump = (pre_cnt_ff < PRE_MAX) ? pre_cnt_ff + PCW'(1) : pre_cnt_ff;
   assign set_bump = (set_cnt_ff < SET_MAX) ? set_cnt_ff + SCW'(1) : set_cnt_ff;

   // Next state of the sequencer.
   always_comb begin
      mode_in    = mode_ff;
      pre_cnt_in = pre_cnt_ff;
      set_cnt_in = set_cnt_ff;
      unique case (mode_ff)
         MODE_UNLOCKED: begin
            if (en && !sev2_in) mode_in = MODE_STANDBY;
         end
         MODE_STANDBY: begin
            if (en && run && !sev2_in) mode_in = MODE_PRECHARGE;
         end
         MODE_PRECHARGE: begin
            pre_cnt_in = pre_bump;
            if (stop) begin
               mode_in    = MODE_SHUTDOWN;
               pre_cnt_in = '0;
            end else if (pre && neg && pre_bump >= PRE_MAX) begin
               mode_in    = MODE_HV;
               pre_cnt_in = '0;
            end
         end
         MODE_HV: begin
            set_cnt_in = set_bump;
            if (stop) begin
               mode_in    = MODE_SHUTDOWN;
               set_cnt_in = '0;
            end else if (pos && neg && set_bump >= SET_MAX) begin
               mode_in    = MODE_RUNNING;
               set_cnt_in = '0;
            end
         end
         MODE_RUNNING: begin
            if (stop) mode_in = MODE_SHUTDOWN;
         end
         MODE_SHUTDOWN: begin
            if ((en && run && !sev2_in) || curr <= release_current_ff) begin
               mode_in = MODE_STANDBY;
            end
         end
         default: begin
            mode_in = MODE_UNLOCKED;
         end
      endcase
   end

   // Result beat: the mode held at the start of the tick and the new flags.
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RSP_STATE_LSB +: 3]  = mode_ff;
      rsp_data_in[RSP_SEV2_BIT]        = sev2_in;
      rsp_data_in[RSP_SEV1_BIT]        = sev1_in;
      rsp_data_in[RSP_FAULT_LSB +: 4]  = fault_in;
      rsp_data_in[RSP_WARN_LSB +: 3]   = warn_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_UNLOCKED;
         pre_cnt_ff   <= '0;
         set_cnt_ff   <= '0;
         fault_ff     <= '0;
         warn_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            mode_ff    <= mode_in;
            pre_cnt_ff <= pre_cnt_in;
            set_cnt_ff <= set_cnt_in;
            fault_ff   <= fault_in;
            warn_ff    <= warn_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) rsp_data_ff <= rsp_data_in;
   end

   // Threshold writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         volt_high_fault_ff <= VOLT_HIGH_FAULT_RST;
         volt_low_fault_ff  <= VOLT_LOW_FAULT_RST;
         volt_high_warn_ff  <= VOLT_HIGH_WARN_RST;
         volt_low_warn_ff   <= VOLT_LOW_WARN_RST;
         curr_high_fault_ff <= CURR_HIGH_FAULT_RST;
         curr_low_fault_ff  <= CURR_LOW_FAULT_RST;
         curr_high_warn_ff  <= CURR_HIGH_WARN_RST;
         release_current_ff <= RELEASE_CURRENT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_VOLT_HIGH_FAULT: volt_high_fault_ff <= csr_data[VOLT_W-1:0];
            CSR_VOLT_LOW_FAULT:  volt_low_fault_ff  <= csr_data[VOLT_W-1:0];
            CSR_VOLT_HIGH_WARN:  volt_high_warn_ff  <= csr_data[VOLT_W-1:0];
            CSR_VOLT_LOW_WARN:   volt_low_warn_ff   <= csr_data[VOLT_W-1:0];
            CSR_CURR_HIGH_FAULT: curr_high_fault_ff <= $signed(csr_data);
            CSR_CURR_LOW_FAULT:  curr_low_fault_ff  <= $signed(csr_data);
            CSR_CURR_HIGH_WARN:  curr_high_warn_ff  <= $signed(csr_data);
            CSR_RELEASE_CURRENT: release_current_ff <= $signed(csr_data);
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ sv/hvps_checker.sv @@
// Port-level checker for the high-voltage precharge sequencer, with its bind.
// Depends on hvps_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module hvps_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic [hvps_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready
);
   import hvps_pkg::*;

   // The output register is empty in the cycle after reset.
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result pending after reset")

   // Every accepted tick beat produces a result beat in the next cycle.
   `ASSERT_RST(a_accept_result, clock, reset, (req_tvalid && req_tready) |=> rsp_tvalid, "accepted beat gave no result")

   // A stalled result holds its payload.
   `ASSERT_RST(a_stall_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled result changed")

   // Severity two is set exactly when some fault cause is latched.
   `ASSERT_RST(a_sev2_causes, clock, reset, rsp_tvalid |-> (rsp_tdata[RSP_SEV2_BIT] == (|rsp_tdata[RSP_FAULT_LSB +: 4])), "sev2 and fault causes disagree")

   // Severity one is set exactly when some warning cause is latched.
   `ASSERT_RST(a_sev1_causes, clock, reset, rsp_tvalid |-> (rsp_tdata[RSP_SEV1_BIT] == (|rsp_tdata[RSP_WARN_LSB +: 3])), "sev1 and warning causes disagree")

endmodule

bind hv_precharge_sequencer hvps_checker u_hvps_checker (.*);

`default_nettype wire
